// File: sv/lpi_pkg.sv
// shared types and constants for the layered profile interpolator
// used by lpi_layer_mem, lpi_lerp_unit and layered_profile_interpolator
package lpi_pkg;

    localparam int MAX_LAYERS_DEF = 64;

    localparam int THICK_W = 20;
    localparam int VAL_W   = 16;
    localparam int DEPTH_W = 21;
    localparam int LIDX_W  = 6;
    localparam int LCNT_W  = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'd1;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef struct packed {
        logic [THICK_W-1:0] thick;
        logic [VAL_W-1:0]   vp;
        logic [VAL_W-1:0]   vs;
        logic [VAL_W-1:0]   rho;
    } layer_t;

    typedef struct packed {
        logic               start;
        logic [VAL_W-1:0]   prev;
        logic [VAL_W-1:0]   cur;
        logic [THICK_W-1:0] off;
        logic [THICK_W-1:0] thick;
    } lerp_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } lerp_rsp_t;

endpackage

// File: sv/lpi_layer_mem.sv
// layer table memory: one write port, one registered read port
// depends on lpi_pkg for the layer_t word
module lpi_layer_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  lpi_pkg::layer_t     wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output lpi_pkg::layer_t     rd_data
);
    import lpi_pkg::*;

    layer_t mem [DEPTH];
    layer_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/lpi_lerp_unit.sv
// shared interpolation unit: one multiply, then a 16-step restoring division
// depends on lpi_pkg for lerp_req_t and lerp_rsp_t
module lpi_lerp_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpi_pkg::lerp_req_t  req,
    output lpi_pkg::lerp_rsp_t  rsp
);
    import lpi_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;
    localparam int PROD_W = VAL_W + THICK_W;

    logic [1:0]         st_reg, st_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [VAL_W-1:0]   prev_reg, prev_next;
    logic [VAL_W-1:0]   mag_reg, mag_next;
    logic [THICK_W-1:0] off_reg, off_next;
    logic [THICK_W-1:0] thick_reg, thick_next;
    logic [THICK_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0]   dq_reg, dq_next;

    logic [PROD_W-1:0]  prod;
    logic [THICK_W:0]   trial;
    logic               qbit;

    assign prod  = PROD_W'(mag_reg) * PROD_W'(off_reg);
    assign trial = {rem_reg, dq_reg[VAL_W-1]};
    assign qbit  = (trial >= {1'b0, thick_reg});

    always_comb begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        prev_next  = prev_reg;
        mag_next   = mag_reg;
        off_next   = off_reg;
        thick_next = thick_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        case (st_reg)
            L_IDLE: begin
                if (req.start) begin
                    neg_next   = (req.cur < req.prev);
                    mag_next   = (req.cur < req.prev) ? (req.prev - req.cur)
                                                      : (req.cur - req.prev);
                    prev_next  = req.prev;
                    off_next   = req.off;
                    thick_next = req.thick;
                    st_next    = L_MUL;
                end
            end
            L_MUL: begin
                // high part is already below the divisor since off < thick
                rem_next = prod[PROD_W-1:VAL_W];
                dq_next  = prod[VAL_W-1:0];
                cnt_next = '0;
                st_next  = L_DIV;
            end
            L_DIV: begin
                rem_next = qbit ? THICK_W'(trial - {1'b0, thick_reg})
                                : THICK_W'(trial);
                dq_next  = {dq_reg[VAL_W-2:0], qbit};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    st_next = L_FIN;
                end
            end
            L_FIN: begin
                st_next = L_IDLE;
            end
            default: begin
                st_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= L_IDLE;
        end else begin
            st_reg <= st_next;
        end
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        prev_reg  <= prev_next;
        mag_reg   <= mag_next;
        off_reg   <= off_next;
        thick_reg <= thick_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
    end

    // quotient truncates toward zero, so apply the sign to the magnitude result
    assign rsp.done  = (st_reg == L_FIN);
    assign rsp.value = neg_reg ? (prev_reg - dq_reg) : (prev_reg + dq_reg);

endmodule

// File: sv/layered_profile_interpolator.sv
// top level of the layered profile interpolator: request sequencer and outputs
// depends on lpi_pkg, lpi_layer_mem and lpi_lerp_unit
// usage
//   s_* carries requests: a load writes one layer slot of the table, a query
//   looks up a point depth plus shift; m_* carries one result per query only
//   cfg_wr_en/cfg_index/cfg_wdata set layer_count and interp_mode; the user must
//   write them only while idle, as the block itself does not enforce it
// sequencing
//   a load leaves the sequencer idle and s_ready stays high
//   an early-out query (already filled, outside domain, negative depth) goes
//   straight to the emit state; any other query walks the table, one layer
//   per cycle, and in linear mode then runs the interpolation unit serially
//   for vp, vs and rho, except at the first or bottom layer
// reset
//   layer_count returns to 1 and interp_mode to step; the table is not
//   cleared, so every layer in use must be loaded before it is queried
// stall
//   a finished result waits in the output register; the next request is
//   taken meanwhile and a new result waits until the receiver drains m_*
module layered_profile_interpolator #(
    parameter int MAX_LAYERS = lpi_pkg::MAX_LAYERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpi_pkg::CFG_W-1:0]       cfg_wdata,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [lpi_pkg::LIDX_W-1:0]      s_layer_index,
    input  logic [lpi_pkg::THICK_W-1:0]     s_thickness_m,
    input  logic [lpi_pkg::VAL_W-1:0]       s_load_vp,
    input  logic [lpi_pkg::VAL_W-1:0]       s_load_vs,
    input  logic [lpi_pkg::VAL_W-1:0]       s_load_rho,
    input  logic signed [lpi_pkg::DEPTH_W-1:0] s_depth_m,
    input  logic signed [lpi_pkg::DEPTH_W-1:0] s_shift_m,
    input  logic                            s_already_filled,
    input  logic                            s_domain_ok,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lpi_pkg::VAL_W-1:0]       m_vp_out,
    output logic [lpi_pkg::VAL_W-1:0]       m_vs_out,
    output logic [lpi_pkg::VAL_W-1:0]       m_rho_out,
    output logic                            m_filled,
    output logic                            m_gap
);
    import lpi_pkg::*;

    localparam int IDX_W = $clog2(MAX_LAYERS);
    localparam int CNT_W = (IDX_W + 1 > LCNT_W) ? IDX_W + 1 : LCNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_LERP  = 3'd2;
    localparam logic [2:0] S_LWAIT = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // channel order inside the value arrays
    localparam logic [1:0] CH_VP  = 2'd0;
    localparam logic [1:0] CH_VS  = 2'd1;
    localparam logic [1:0] CH_RHO = 2'd2;

    logic [2:0]          state_reg, state_next;
    logic [LCNT_W-1:0]   layer_count_reg, layer_count_next;
    logic                interp_mode_reg, interp_mode_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [DEPTH_W-1:0]  top_reg, top_next;     // running top, never above depth
    logic [DEPTH_W-1:0]  d_reg, d_next;
    logic [THICK_W-1:0]  off_reg, off_next;
    logic [THICK_W-1:0]  thick_reg, thick_next;
    logic [1:0]          ch_reg, ch_next;

    logic [VAL_W-1:0]    prev_reg [3];
    logic [VAL_W-1:0]    prev_next [3];
    logic [VAL_W-1:0]    cur_reg [3];
    logic [VAL_W-1:0]    cur_next [3];
    logic [VAL_W-1:0]    res_reg [3];
    logic [VAL_W-1:0]    res_next [3];
    logic                res_filled_reg, res_filled_next;
    logic                res_gap_reg, res_gap_next;

    logic                m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]    m_vp_reg, m_vp_next;
    logic [VAL_W-1:0]    m_vs_reg, m_vs_next;
    logic [VAL_W-1:0]    m_rho_reg, m_rho_next;
    logic                m_filled_reg, m_filled_next;
    logic                m_gap_reg, m_gap_next;

    // table access
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    layer_t              mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    layer_t              rd_data;
    logic [VAL_W-1:0]    rd_val [3];

    // interpolation unit
    lerp_req_t           lerp_req;
    lerp_rsp_t           lerp_rsp;

    // query front end
    logic                in_fire;
    logic signed [DEPTH_W:0] depth_sum;
    logic [CNT_W-1:0]    lc_ext;
    logic [IDX_W-1:0]    last_calc;

    // walk step
    logic [DEPTH_W:0]    bottom;
    logic                hit;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;

    // loads go straight into the table; slots beyond the table are dropped
    assign mem_we    = in_fire && (s_opcode == OP_LOAD)
                       && (int'(s_layer_index) < MAX_LAYERS);
    assign mem_waddr = IDX_W'(s_layer_index);
    assign mem_wdata = '{thick: s_thickness_m, vp: s_load_vp,
                         vs: s_load_vs, rho: s_load_rho};
    // read address runs one ahead of idx_reg, so rd_data always holds the
    // layer at idx_reg while walking
    assign mem_raddr = (state_reg == S_WALK) ? IDX_W'(idx_reg + 1'b1) : '0;

    lpi_layer_mem #(
        .DEPTH  (MAX_LAYERS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_data)
    );

    assign rd_val[CH_VP]  = rd_data.vp;
    assign rd_val[CH_VS]  = rd_data.vs;
    assign rd_val[CH_RHO] = rd_data.rho;

    assign lerp_req.start = (state_reg == S_LERP);
    assign lerp_req.prev  = prev_reg[ch_reg];
    assign lerp_req.cur   = cur_reg[ch_reg];
    assign lerp_req.off   = off_reg;
    assign lerp_req.thick = thick_reg;

    lpi_lerp_unit u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lerp_req),
        .rsp     (lerp_rsp)
    );

    // depth plus shift, one bit wider so it cannot overflow
    assign depth_sum = (DEPTH_W+1)'(s_depth_m) + (DEPTH_W+1)'(s_shift_m);

    // last layer in use, with zero taken as one and the count clamped
    assign lc_ext = CNT_W'(layer_count_reg);
    always_comb begin
        if (layer_count_reg == '0) begin
            last_calc = '0;
        end else if (lc_ext > CNT_W'(MAX_LAYERS)) begin
            last_calc = IDX_W'(MAX_LAYERS - 1);
        end else begin
            last_calc = IDX_W'(lc_ext - 1'b1);
        end
    end

    assign bottom = {1'b0, top_reg} + (DEPTH_W+1)'(rd_data.thick);
    assign hit    = (bottom > {1'b0, d_reg});

    always_comb begin
        state_next       = state_reg;
        layer_count_next = layer_count_reg;
        interp_mode_next = interp_mode_reg;
        idx_next         = idx_reg;
        last_next        = last_reg;
        top_next         = top_reg;
        d_next           = d_reg;
        off_next         = off_reg;
        thick_next       = thick_reg;
        ch_next          = ch_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        res_next         = res_reg;
        res_filled_next  = res_filled_reg;
        res_gap_next     = res_gap_reg;
        m_valid_next     = m_valid_reg;
        m_vp_next        = m_vp_reg;
        m_vs_next        = m_vs_reg;
        m_rho_next       = m_rho_reg;
        m_filled_next    = m_filled_reg;
        m_gap_next       = m_gap_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LAYER_COUNT: layer_count_next = LCNT_W'(cfg_wdata);
                REG_INTERP_MODE: interp_mode_next = cfg_wdata[0];
                default: ;
            endcase
        end

        // receiver drains the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_opcode == OP_QUERY)) begin
                    res_next[CH_VP]  = '0;
                    res_next[CH_VS]  = '0;
                    res_next[CH_RHO] = '0;
                    res_filled_next  = 1'b0;
                    res_gap_next     = 1'b0;
                    if (s_already_filled) begin
                        state_next = S_EMIT;
                    end else if (!s_domain_ok || depth_sum[DEPTH_W]) begin
                        // outside the domains or above the surface
                        res_gap_next = 1'b1;
                        state_next   = S_EMIT;
                    end else begin
                        d_next     = depth_sum[DEPTH_W-1:0];
                        top_next   = '0;
                        idx_next   = '0;
                        last_next  = last_calc;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (hit || (idx_reg == last_reg)) begin
                    res_filled_next = 1'b1;
                    if ((idx_reg == last_reg) || (idx_reg == '0) || !interp_mode_reg) begin
                        // own values: first layer, bottom layer or step mode
                        res_next   = rd_val;
                        state_next = S_EMIT;
                    end else begin
                        cur_next   = rd_val;
                        off_next   = THICK_W'(d_reg - top_reg);
                        thick_next = rd_data.thick;
                        ch_next    = CH_VP;
                        state_next = S_LERP;
                    end
                end else begin
                    prev_next = rd_val;
                    top_next  = bottom[DEPTH_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_LERP: begin
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                if (lerp_rsp.done) begin
                    res_next[ch_reg] = lerp_rsp.value;
                    if (ch_reg == CH_RHO) begin
                        state_next = S_EMIT;
                    end else begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_LERP;
                    end
                end
            end
            S_EMIT: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_vp_next     = res_reg[CH_VP];
                    m_vs_next     = res_reg[CH_VS];
                    m_rho_next    = res_reg[CH_RHO];
                    m_filled_next = res_filled_reg;
                    m_gap_next    = res_gap_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            layer_count_reg <= LCNT_W'(1);
            interp_mode_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            layer_count_reg <= layer_count_next;
            interp_mode_reg <= interp_mode_next;
            m_valid_reg     <= m_valid_next;
        end
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        top_reg        <= top_next;
        d_reg          <= d_next;
        off_reg        <= off_next;
        thick_reg      <= thick_next;
        ch_reg         <= ch_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        res_reg        <= res_next;
        res_filled_reg <= res_filled_next;
        res_gap_reg    <= res_gap_next;
        m_vp_reg       <= m_vp_next;
        m_vs_reg       <= m_vs_next;
        m_rho_reg      <= m_rho_next;
        m_filled_reg   <= m_filled_next;
        m_gap_reg      <= m_gap_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_vp_out  = m_vp_reg;
    assign m_vs_out  = m_vs_reg;
    assign m_rho_out = m_rho_reg;
    assign m_filled  = m_filled_reg;
    assign m_gap     = m_gap_reg;

endmodule

// File: tb/tb_layered_profile_interpolator.sv
`timescale 1ns / 1ps
// self-checking testbench for layered_profile_interpolator: loads layer tables,
// queries point depths and checks every result against an in-bench lookup model
// depends on lpi_pkg and the layered_profile_interpolator rtl
module tb_layered_profile_interpolator;
    import lpi_pkg::*;

    localparam int     LAYERS         = MAX_LAYERS_DEF;
    localparam int     TARGET_ITEMS   = 1200;
    localparam int     CALM_ITEMS     = 1050;
    // room for a walk over 64 layers plus three serial divides
    localparam int     SETTLE_CYCLES  = 200;
    localparam int     STUCK_LIMIT    = 5000;
    localparam int     HOLD_AT_RESULT = 250;
    localparam int     HOLD_CYCLES    = 700;
    localparam int     DEPTH_MAX      = 1048575;
    localparam longint SUM_MAX        = 2097150;

    // one request as offered on s_*
    typedef struct {
        logic               opcode;
        logic [LIDX_W-1:0]  layer_index;
        logic [THICK_W-1:0] thickness_m;
        logic [VAL_W-1:0]   vp, vs, rho;
        int                 depth_m, shift_m;
        logic               already_filled, domain_ok;
    } request_t;

    // one result as seen on m_*
    typedef struct packed {
        logic [VAL_W-1:0] vp, vs, rho;
        logic             filled, gap;
    } profile_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    logic                      s_valid          = 1'b0;
    logic                      s_ready;
    logic                      s_opcode         = OP_QUERY;
    logic [LIDX_W-1:0]         s_layer_index    = '0;
    logic [THICK_W-1:0]        s_thickness_m    = '0;
    logic [VAL_W-1:0]          s_load_vp        = '0;
    logic [VAL_W-1:0]          s_load_vs        = '0;
    logic [VAL_W-1:0]          s_load_rho       = '0;
    logic signed [DEPTH_W-1:0] s_depth_m        = '0;
    logic signed [DEPTH_W-1:0] s_shift_m        = '0;
    logic                      s_already_filled = 1'b0;
    logic                      s_domain_ok      = 1'b0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [VAL_W-1:0] m_vp_out, m_vs_out, m_rho_out;
    logic             m_filled, m_gap;

    // lookup model state, updated as requests are accepted
    logic [THICK_W-1:0] thick_mem [LAYERS];
    logic [VAL_W-1:0]   vp_mem    [LAYERS];
    logic [VAL_W-1:0]   vs_mem    [LAYERS];
    logic [VAL_W-1:0]   rho_mem   [LAYERS];
    logic [LCNT_W-1:0]  cur_layer_count = 7'd1;
    logic               cur_mode        = 1'b0;

    // the table as it will stand once every queued load is in; used to aim queries
    logic [THICK_W-1:0] plan_thick  [LAYERS];
    bit                 plan_loaded [LAYERS];

    request_t pending_requests [$];
    profile_t expected_values  [$];
    request_t sent_request;

    int items_queued   = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int stuck_cycles   = 0;
    bit hold_done      = 1'b0;
    bit idle_on        = 1'b1;
    bit calm           = 1'b0;

    layered_profile_interpolator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_layer_index    (s_layer_index),
        .s_thickness_m    (s_thickness_m),
        .s_load_vp        (s_load_vp),
        .s_load_vs        (s_load_vs),
        .s_load_rho       (s_load_rho),
        .s_depth_m        (s_depth_m),
        .s_shift_m        (s_shift_m),
        .s_already_filled (s_already_filled),
        .s_domain_ok      (s_domain_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_vp_out         (m_vp_out),
        .m_vs_out         (m_vs_out),
        .m_rho_out        (m_rho_out),
        .m_filled         (m_filled),
        .m_gap            (m_gap)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // lookup model
    // ------------------------------------------------------------------

    // layer_count 0 acts as one layer, anything past the table as the full table
    function automatic int active_layers(logic [LCNT_W-1:0] count);
        if (count == 0) return 1;
        if (count > LAYERS) return LAYERS;
        return int'(count);
    endfunction

    // prev + (cur - prev) * off / thick, division truncated toward zero
    function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] prev, logic [VAL_W-1:0] cur,
                                               longint off, longint thick);
        longint q;
        if (thick <= 0) return cur;
        q = ((longint'(cur) - longint'(prev)) * off) / thick;
        return VAL_W'(longint'(prev) + q);
    endfunction

    function automatic profile_t lookup_profile(request_t r);
        profile_t res;
        longint   d, top, bottom;
        int       n, sel, i;
        bit       found;
        res = '0;
        d = longint'(r.depth_m) + longint'(r.shift_m);
        // a point that already holds values gets nothing, not even a gap
        if (r.already_filled) return res;
        if (!r.domain_ok || d < 0) begin
            res.gap = 1'b1;
            return res;
        end
        n     = active_layers(cur_layer_count);
        top   = 0;
        found = 1'b0;
        sel   = n - 1;
        // first layer whose bottom lies strictly below the depth
        for (i = 0; i < n && !found; i++) begin
            bottom = top + longint'(thick_mem[i]);
            if (bottom > d) begin
                found = 1'b1;
                sel   = i;
            end else begin
                top = bottom;
            end
        end
        // below all layers, bottom layer, first layer and step mode: own values
        if (!found || sel == n - 1 || sel == 0 || !cur_mode) begin
            res.vp  = vp_mem[sel];
            res.vs  = vs_mem[sel];
            res.rho = rho_mem[sel];
        end else begin
            res.vp  = blend(vp_mem[sel-1],  vp_mem[sel],  d - top, longint'(thick_mem[sel]));
            res.vs  = blend(vs_mem[sel-1],  vs_mem[sel],  d - top, longint'(thick_mem[sel]));
            res.rho = blend(rho_mem[sel-1], rho_mem[sel], d - top, longint'(thick_mem[sel]));
        end
        res.filled = 1'b1;
        return res;
    endfunction

    // one accepted request: a load writes its slot, a query owes one result
    function automatic void apply_request(request_t r);
        if (r.opcode == OP_LOAD) begin
            thick_mem[r.layer_index] = r.thickness_m;
            vp_mem[r.layer_index]    = r.vp;
            vs_mem[r.layer_index]    = r.vs;
            rho_mem[r.layer_index]   = r.rho;
        end else begin
            expected_values.push_back(lookup_profile(r));
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int random_depth();
        return int'($urandom_range(0, 2 * DEPTH_MAX)) - DEPTH_MAX;
    endfunction

    // every field random; the callers then fix what the request is meant to do
    function automatic request_t random_request();
        request_t r;
        r.opcode         = 1'($urandom);
        r.layer_index    = LIDX_W'($urandom);
        r.thickness_m    = THICK_W'($urandom);
        r.vp             = VAL_W'($urandom);
        r.vs             = VAL_W'($urandom);
        r.rho            = VAL_W'($urandom);
        r.depth_m        = random_depth();
        r.shift_m        = random_depth();
        r.already_filled = 1'($urandom);
        r.domain_ok      = 1'($urandom);
        return r;
    endfunction

    function automatic logic [THICK_W-1:0] random_thickness(int n, int style);
        int     roll;
        longint hi;
        roll = $urandom_range(0, 99);
        hi   = SUM_MAX / n;
        if (hi > DEPTH_MAX) hi = DEPTH_MAX;
        if (roll < 8) return '0;
        if (roll < 12) return THICK_W'($urandom);
        if (style == 0) return THICK_W'($urandom_range(1, 64));
        return THICK_W'($urandom_range(1, 32'(hi)));
    endfunction

    task automatic queue_load(int idx, logic [THICK_W-1:0] thick,
                              logic [VAL_W-1:0] vp, logic [VAL_W-1:0] vs,
                              logic [VAL_W-1:0] rho);
        request_t r;
        r             = random_request();
        r.opcode      = OP_LOAD;
        r.layer_index = LIDX_W'(idx);
        r.thickness_m = thick;
        r.vp          = vp;
        r.vs          = vs;
        r.rho         = rho;
        plan_thick[idx]  = thick;
        plan_loaded[idx] = 1'b1;
        pending_requests.push_back(r);
        items_queued++;
        // the phase that reaches the last part of the run goes without idling
        if (items_queued > CALM_ITEMS) calm = 1'b1;
    endtask

    task automatic queue_query(int depth, int shift, bit already_filled, bit domain_ok);
        request_t r;
        r                = random_request();
        r.opcode         = OP_QUERY;
        r.depth_m        = depth;
        r.shift_m        = shift;
        r.already_filled = already_filled;
        r.domain_ok      = domain_ok;
        pending_requests.push_back(r);
        items_queued++;
        if (items_queued > CALM_ITEMS) calm = 1'b1;
    endtask

    // split a wanted depth sum into a random depth and the matching shift
    task automatic queue_depth(longint d);
        longint lo, hi, depth;
        if (d > SUM_MAX) d = SUM_MAX;
        if (d < -SUM_MAX) d = -SUM_MAX;
        lo = (d - DEPTH_MAX > -DEPTH_MAX) ? d - DEPTH_MAX : -DEPTH_MAX;
        hi = (d + DEPTH_MAX < DEPTH_MAX) ? d + DEPTH_MAX : DEPTH_MAX;
        depth = lo + longint'($urandom_range(0, 32'(hi - lo)));
        queue_query(int'(depth), int'(d - depth), 1'b0, 1'b1);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_LAYER_COUNT)
            cur_layer_count = value;
        else
            cur_mode = value[0];
    endtask

    // wait until every request is in and every result is out, then let any
    // trailing load or walk finish; sampled at the falling edge to stay clear
    // of the updates made at the rising edge
    task automatic settle();
        while (pending_requests.size() != 0 || s_valid || expected_values.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // one random phase: new setting, fill any unloaded layers in use, then
    // mostly aimed queries with some noise and stray loads
    task automatic run_phase(logic [LCNT_W-1:0] count_word, bit mode);
        longint           tops [LAYERS+1];
        longint           d, span;
        logic [CFG_W-1:0] mode_word;
        int               n, style, queries, q, i, j, pick;
        bit               fresh;
        settle();
        if (items_queued >= CALM_ITEMS) calm = 1'b1;
        idle_on = ($urandom_range(0, 3) != 0);
        write_register(REG_LAYER_COUNT, count_word);
        // bits above the mode bit carry no meaning
        mode_word    = CFG_W'($urandom);
        mode_word[0] = mode;
        write_register(REG_INTERP_MODE, mode_word);
        n     = active_layers(count_word);
        style = $urandom_range(0, 1);
        fresh = ($urandom_range(0, 2) == 0);
        for (i = 0; i < n; i++) begin
            if (!plan_loaded[i] || fresh || $urandom_range(0, 7) == 0)
                queue_load(i, random_thickness(n, style), VAL_W'($urandom),
                           VAL_W'($urandom), VAL_W'($urandom));
        end
        queries = $urandom_range(20, 90);
        for (q = 0; q < queries; q++) begin
            tops[0] = 0;
            for (i = 0; i < n; i++) tops[i+1] = tops[i] + longint'(plan_thick[i]);
            span = (tops[n] < SUM_MAX) ? tops[n] : SUM_MAX;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // stray load to any slot, live layers included
                queue_load($urandom_range(0, LAYERS - 1), random_thickness(n, style),
                           VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
            end else if (pick < 16) begin
                queue_query(random_depth(), random_depth(), 1'($urandom), 1'($urandom));
            end else if (pick < 22) begin
                queue_depth(-longint'($urandom_range(1, 32'(SUM_MAX))));
            end else if (pick < 30) begin
                queue_depth(tops[n] + longint'($urandom_range(0, 1000)));
            end else if (pick < 40) begin
                queue_depth(longint'($urandom_range(0, 32'(span))));
            end else begin
                // aim at a layer: its top, just above its bottom, its bottom, inside
                j = $urandom_range(0, n - 1);
                case ($urandom_range(0, 3))
                    0: d = tops[j];
                    1: d = tops[j+1] - 1;
                    2: d = tops[j+1];
                    default: begin
                        d = tops[j];
                        if (plan_thick[j] != 0)
                            d += longint'($urandom_range(0, 32'(plan_thick[j]) - 1));
                    end
                endcase
                queue_depth(d);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // request taken at this edge: bring the model up to date
            if (s_valid && s_ready) apply_request(sent_request);
            // valid holds until accepted; only then may a gap or a new request follow
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    sent_request = pending_requests.pop_front();
                    s_opcode         <= sent_request.opcode;
                    s_layer_index    <= sent_request.layer_index;
                    s_thickness_m    <= sent_request.thickness_m;
                    s_load_vp        <= sent_request.vp;
                    s_load_vs        <= sent_request.vs;
                    s_load_rho       <= sent_request.rho;
                    s_depth_m        <= DEPTH_W'(sent_request.depth_m);
                    s_shift_m        <= DEPTH_W'(sent_request.shift_m);
                    s_already_filled <= sent_request.already_filled;
                    s_domain_ok      <= sent_request.domain_ok;
                    s_valid          <= 1'b1;
                    // idle burst after this request has gone
                    if (!calm && idle_on && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        profile_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_vp_out, m_vs_out, m_rho_out, m_filled, m_gap};
                results_seen++;
                if (expected_values.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no query waiting, expected none, actual vp=%0d",
                             $time, got.vp, " vs=%0d rho=%0d filled=%0b gap=%0b",
                             got.vs, got.rho, got.filled, got.gap);
                end else begin
                    want = expected_values.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: result mismatch, expected vp=%0d vs=%0d rho=%0d",
                                 $time, want.vp, want.vs, want.rho,
                                 " filled=%0b gap=%0b, actual vp=%0d vs=%0d rho=%0d",
                                 want.filled, want.gap, got.vp, got.vs, got.rho,
                                 " filled=%0b gap=%0b", got.filled, got.gap);
                    end
                end
            end
            // one long hold-off while requests are still queued, so the block
            // backs up and stalls s_ready
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT_RESULT
                         && pending_requests.size() >= 8) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready  <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("layered_profile_interpolator verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [LCNT_W-1:0] edge_counts [5];
        bit                edge_modes  [5];
        logic [LCNT_W-1:0] count_word;
        int                p, roll;
        edge_counts = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd65};
        edge_modes  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed profile: a zero-thickness layer, a thin layer, a maximal bottom layer
        write_register(REG_LAYER_COUNT, 7'd5);
        write_register(REG_INTERP_MODE, 7'd0);
        queue_load(0, 20'd1000, 16'd0, 16'd0, 16'd0);
        queue_load(1, 20'd0, 16'hffff, 16'hffff, 16'hffff);
        queue_load(2, 20'd3000, 16'd40000, 16'd100, 16'hffff);
        queue_load(3, 20'd7, 16'd9, 16'd60000, 16'd1);
        queue_load(4, 20'hfffff, 16'd1234, 16'hffff, 16'd0);

        // step mode
        queue_query(0, 0, 1'b1, 1'b1);                // already filled
        queue_query(500, 0, 1'b1, 1'b0);              // filled wins over out of domain
        queue_query(500, 0, 1'b0, 1'b0);              // outside both domains
        queue_query(-5, 2, 1'b0, 1'b1);               // negative sum
        queue_query(-DEPTH_MAX, DEPTH_MAX, 1'b0, 1'b1); // sum exactly zero
        queue_query(999, 0, 1'b0, 1'b1);
        queue_query(1000, 0, 1'b0, 1'b1);             // zero-thickness layer skipped
        queue_query(3999, 0, 1'b0, 1'b1);
        queue_query(4000, 0, 1'b0, 1'b1);
        queue_query(4006, 0, 1'b0, 1'b1);
        queue_query(4007, 0, 1'b0, 1'b1);             // bottom layer
        queue_query(DEPTH_MAX, DEPTH_MAX, 1'b0, 1'b1);  // below all layers

        // linear mode, with junk above the mode bit
        settle();
        write_register(REG_INTERP_MODE, 7'h55);
        queue_query(2500, 0, 1'b0, 1'b1);             // falling and flat ranges
        queue_query(1000, 0, 1'b0, 1'b1);             // zero offset gives the layer above
        queue_query(4003, -2, 1'b0, 1'b1);            // thin layer, truncation
        queue_query(500, 0, 1'b0, 1'b1);              // first layer
        queue_query(10000, 0, 1'b0, 1'b1);            // bottom layer
        queue_query(DEPTH_MAX, DEPTH_MAX, 1'b0, 1'b1);

        // random phases, the layer count extremes first
        p = 0;
        while (items_queued < TARGET_ITEMS) begin
            if (p < 5) begin
                run_phase(edge_counts[p], edge_modes[p]);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    count_word = LCNT_W'($urandom_range(2, 12));
                else if (roll < 90)
                    count_word = LCNT_W'($urandom_range(13, 64));
                else
                    count_word = LCNT_W'($urandom_range(0, 127));
                run_phase(count_word, 1'($urandom));
            end
            p++;
        end

        settle();
        if (mismatch_count == 0)
            $display("layered_profile_interpolator verification clean");
        else
            $display("layered_profile_interpolator verification failed");
        $finish;
    end

endmodule
